### rtl/psbs_pkg.sv
// Shared types, constants and arithmetic helpers for the particle staircase bounce step.
package psbs_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_FIELDS_W = 129;
  localparam int IN_DATA_W = 136;
  localparam int OUT_FIELDS_W = 67;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY    = 3'd0,
    REG_DRAG_V     = 3'd1,
    REG_DRAG_H     = 3'd2,
    REG_REST_FLOOR = 3'd3,
    REG_REST_SIDE  = 3'd4,
    REG_LEFT_BOUND = 3'd5
  } psbs_reg_t;

  typedef struct packed {
    logic [7:0] gravity;
    logic [7:0] drag_v;
    logic [7:0] drag_h;
    logic [7:0] rest_floor;
    logic [7:0] rest_side;
    logic [9:0] left_bound;
  } psbs_cfg_t;

  localparam logic [7:0] GRAVITY_RST    = 8'd35;
  localparam logic [7:0] DRAG_V_RST     = 8'd3;
  localparam logic [7:0] DRAG_H_RST     = 8'd0;
  localparam logic [7:0] REST_FLOOR_RST = 8'd25;
  localparam logic [7:0] REST_SIDE_RST  = 8'd35;
  localparam logic [9:0] LEFT_BOUND_RST = 10'd0;

  // Pixel to fixed point with five fraction bits.
  function automatic logic signed [16:0] px(input int n);
    return 17'(n * 32);
  endfunction

  localparam logic signed [16:0] STAIR_SUM   = px(640);
  localparam logic signed [16:0] COL_NONE    = px(159);
  localparam logic signed [16:0] COL_LOW     = px(280);
  localparam logic signed [16:0] COL_MID     = px(400);
  localparam logic signed [16:0] COL_HIGH    = px(520);
  localparam logic signed [16:0] WALL_279    = px(279);
  localparam logic signed [16:0] WALL_399    = px(399);
  localparam logic signed [16:0] WALL_519    = px(519);
  localparam logic signed [16:0] WALL_639    = px(639);
  localparam logic signed [16:0] ROW_479     = px(479);
  localparam logic signed [16:0] ROW_359     = px(359);
  localparam logic signed [16:0] ROW_239     = px(239);
  localparam logic signed [16:0] ROW_119     = px(119);

  localparam logic signed [15:0] POS_FLOOR   = 16'(px(478));
  localparam logic signed [15:0] POS_ROW_479 = 16'(px(474));
  localparam logic signed [15:0] POS_ROW_359 = 16'(px(354));
  localparam logic signed [15:0] POS_ROW_239 = 16'(px(234));
  localparam logic signed [15:0] POS_ROW_119 = 16'(px(114));
  localparam logic signed [15:0] POS_COL_279 = 16'(px(274));
  localparam logic signed [15:0] POS_COL_399 = 16'(px(394));
  localparam logic signed [15:0] POS_COL_519 = 16'(px(514));
  localparam logic signed [15:0] POS_COL_639 = 16'(px(634));

  localparam logic signed [15:0] SPAWN_X_BASE  = 16'(px(640));
  localparam logic signed [15:0] SPAWN_VX_BASE = -16'sd96;
  localparam logic [2:0]         SPAWN_Y_MASK  = 3'b101;

  localparam logic [10:0] DRAW_SPAN_VX = 11'd2000;
  localparam logic [11:0] DRAW_SPAN    = 12'd4000;

  // floor(n/125) for n below 59074 by a reciprocal multiply.
  localparam logic [30:0] RECIP_125   = 31'd33555;
  localparam int          RECIP_SHIFT = 22;

  function automatic logic [7:0] div125(input logic [14:0] n);
    logic [30:0] p;
    p = {16'd0, n} * RECIP_125;
    return 8'(p >> RECIP_SHIFT);
  endfunction

  function automatic logic [11:0] reduce_draw(input logic [11:0] r);
    return (r >= DRAW_SPAN) ? r - DRAW_SPAN : r;
  endfunction

  // Signed 16-bit value times an unsigned 8-bit factor.
  function automatic logic signed [24:0] fprod(input logic signed [15:0] v,
                                               input logic [7:0] k);
    logic signed [24:0] vs;
    logic signed [24:0] ks;
    vs = 25'(v);
    ks = {17'd0, k};
    return vs * ks;
  endfunction

  function automatic logic in_square(input logic signed [15:0] x,
                                     input logic signed [15:0] y);
    logic signed [16:0] xs;
    logic signed [16:0] ys;
    xs = {x[15], x};
    ys = {y[15], y};
    return (xs >= px(519) && xs <= px(530) && ys >= px(119) && ys <= px(130)) ||
           (xs >= px(399) && xs <= px(410) && ys >= px(239) && ys <= px(250)) ||
           (xs >= px(279) && xs <= px(290) && ys >= px(359) && ys <= px(370));
  endfunction

endpackage

### rtl/psbs_cfg.sv
// Configuration register file for the particle staircase bounce step.
module psbs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_valid,
  output logic                                wr_ready,
  input  logic [psbs_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [psbs_pkg::CFG_DATA_W-1:0]     wr_data,
  output psbs_pkg::psbs_cfg_t                 regs
);
  import psbs_pkg::*;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gravity    <= GRAVITY_RST;
      regs.drag_v     <= DRAG_V_RST;
      regs.drag_h     <= DRAG_H_RST;
      regs.rest_floor <= REST_FLOOR_RST;
      regs.rest_side  <= REST_SIDE_RST;
      regs.left_bound <= LEFT_BOUND_RST;
    end else if (wr_valid) begin
      case (psbs_reg_t'(wr_index))
        REG_GRAVITY:    regs.gravity    <= wr_data[7:0];
        REG_DRAG_V:     regs.drag_v     <= wr_data[7:0];
        REG_DRAG_H:     regs.drag_h     <= wr_data[7:0];
        REG_REST_FLOOR: regs.rest_floor <= wr_data[7:0];
        REG_REST_SIDE:  regs.rest_side  <= wr_data[7:0];
        REG_LEFT_BOUND: regs.left_bound <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/particle_staircase_bounce_step_top.sv
// Six-stage particle update pipeline: drag, respawn, staircase and floor bounce.
//
//   channel   direction   handshake                 carries
//   s_*       in          s_tvalid / s_tready       particle state and random draws
//   m_*       out         m_tvalid / m_tready       new state and flags
//   cfg_*     in          cfg_valid / cfg_ready     register index and value
//
// One particle enters per cycle unless the output stalls the pipeline.
// The six register stages follow the dependent multiplies: drag, reciprocal
// division of the draws, respawn choice, restitution product, bounce, final add.
// Reset is synchronous and clears the stage valid bits, not the data registers.
// A full stage holds only while the stage after it is held, so bubbles close up.
module particle_staircase_bounce_step_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x, pos_y, vel_x, vel_y, rand_spawn_x, rand_spawn_y, rand_spawn_vx,
  // rand_spawn_vy_a, rand_spawn_vy_b, rand_jitter_floor, rand_jitter_side, zero fill
  input  logic [psbs_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // new_x, new_y, new_vx, new_vy, bounced, erase_old, draw_new, zero fill
  output logic [psbs_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import psbs_pkg::*;

  psbs_cfg_t cfg;

  psbs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg_valid),
    .wr_ready (cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  logic [5:0] vld;
  logic [5:0] vld_next;
  logic [5:0] en;

  always_comb begin
    en[5] = !vld[5] || m_tready;
    for (int i = 4; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
    vld_next[0] = en[0] ? s_tvalid : vld[0];
    for (int i = 1; i < 6; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[5];

  logic signed [16:0] left_px;
  assign left_px = {2'b00, cfg.left_bound, 5'd0};

  logic signed [15:0] in_x, in_y, in_vx, in_vy;
  logic [2:0]  in_rsx, in_rsy;
  logic [10:0] in_rvx;
  logic [11:0] in_rva, in_rvb, in_rjf, in_rjs;

  assign in_x   = s_tdata[15:0];
  assign in_y   = s_tdata[31:16];
  assign in_vx  = s_tdata[47:32];
  assign in_vy  = s_tdata[63:48];
  assign in_rsx = s_tdata[66:64];
  assign in_rsy = s_tdata[69:67];
  assign in_rvx = s_tdata[80:70];
  assign in_rva = s_tdata[92:81];
  assign in_rvb = s_tdata[104:93];
  assign in_rjf = s_tdata[116:105];
  assign in_rjs = s_tdata[128:117];

  // Stage 1: drag products, draw conditioning, spawn position, erase test.
  logic [10:0]        rvx_red;
  logic [11:0]        a_red, b_red, jf_red, js_red, d_mag;
  logic signed [12:0] d_ab;

  always_comb begin
    rvx_red = (in_rvx >= DRAW_SPAN_VX) ? in_rvx - DRAW_SPAN_VX : in_rvx;
    a_red   = reduce_draw(in_rva);
    b_red   = reduce_draw(in_rvb);
    jf_red  = reduce_draw(in_rjf);
    js_red  = reduce_draw(in_rjs);
    d_ab    = $signed({1'b0, a_red}) - $signed({1'b0, b_red});
    d_mag   = d_ab[12] ? 12'(-d_ab) : d_ab[11:0];
  end

  logic signed [15:0] x_s1, y_s1, vx_s1, vy_s1, sx_s1, sy_s1;
  logic signed [24:0] pdh_s1, pdv_s1;
  logic [11:0]        nvx_s1;
  logic [12:0]        nvy_s1;
  logic [14:0]        njf_s1, njs_s1;
  logic               neg_s1, erase_s1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_s1     <= in_x;
      y_s1     <= in_y;
      vx_s1    <= in_vx;
      vy_s1    <= in_vy;
      pdh_s1   <= fprod(in_vx, cfg.drag_h);
      pdv_s1   <= fprod(in_vy, cfg.drag_v);
      nvx_s1   <= {rvx_red, 1'b0};
      nvy_s1   <= {d_mag, 1'b0};
      njf_s1   <= {1'b0, jf_red, 2'b00} + {2'b00, jf_red, 1'b0};
      njs_s1   <= {1'b0, js_red, 2'b00} + {2'b00, js_red, 1'b0};
      neg_s1   <= d_ab[12];
      sx_s1    <= SPAWN_X_BASE - {8'd0, in_rsx, 5'd0};
      sy_s1    <= {8'd0, in_rsy & SPAWN_Y_MASK, 5'd0};
      erase_s1 <= !in_square(in_x, in_y);
    end
  end

  // Stage 2: apply drag and gravity, divide the draws by 125.
  logic signed [15:0] x_s2, y_s2, vx_s2, vy_s2, sx_s2, sy_s2;
  logic [4:0]         qvx_s2;
  logic [5:0]         qvy_s2;
  logic [7:0]         jf_s2, js_s2;
  logic               neg_s2, erase_s2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_s2     <= x_s1;
      y_s2     <= y_s1;
      vx_s2    <= vx_s1 - pdh_s1[20:5];
      vy_s2    <= vy_s1 + {8'd0, cfg.gravity} - pdv_s1[20:5];
      qvx_s2   <= 5'(div125({3'd0, nvx_s1}));
      qvy_s2   <= 6'(div125({2'd0, nvy_s1}));
      jf_s2    <= div125(njf_s1);
      js_s2    <= div125(njs_s1);
      neg_s2   <= neg_s1;
      sx_s2    <= sx_s1;
      sy_s2    <= sy_s1;
      erase_s2 <= erase_s1;
    end
  end

  // Stage 3: first left-bound test and respawn.
  logic signed [16:0] sum_xv2;
  logic               resp_a;
  logic signed [15:0] svx2, svy2;

  always_comb begin
    sum_xv2 = {x_s2[15], x_s2} + {vx_s2[15], vx_s2};
    resp_a  = sum_xv2 < left_px;
    svx2    = SPAWN_VX_BASE - {11'd0, qvx_s2};
    svy2    = neg_s2 ? {10'd0, qvy_s2} : 16'd0 - {10'd0, qvy_s2};
  end

  logic signed [15:0] x_s3, y_s3, vx_s3, vy_s3, sx_s3, sy_s3, svx_s3, svy_s3;
  logic [7:0]         jf_s3, js_s3;
  logic               erase_s3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x_s3     <= resp_a ? sx_s2 : x_s2;
      y_s3     <= resp_a ? sy_s2 : y_s2;
      vx_s3    <= resp_a ? svx2 : vx_s2;
      vy_s3    <= resp_a ? svy2 : vy_s2;
      sx_s3    <= sx_s2;
      sy_s3    <= sy_s2;
      svx_s3   <= svx2;
      svy_s3   <= svy2;
      jf_s3    <= jf_s2;
      js_s3    <= js_s2;
      erase_s3 <= erase_s2;
    end
  end

  // Stage 4: wall decisions, second left-bound test and restitution products.
  logic signed [16:0] nx3, ny3, sxy3, brow3, rcol3;
  logic signed [15:0] bpos3, rpos3;
  logic               stair3, has_right3, hb_st3, hr3;

  always_comb begin
    nx3        = {x_s3[15], x_s3} + {vx_s3[15], vx_s3};
    ny3        = {y_s3[15], y_s3} + {vy_s3[15], vy_s3};
    sxy3       = {x_s3[15], x_s3} + {y_s3[15], y_s3};
    stair3     = sxy3 >= STAIR_SUM;
    has_right3 = 1'b1;
    if (nx3 <= COL_NONE) begin
      has_right3 = 1'b0;
      rcol3 = WALL_279;
      rpos3 = POS_COL_279;
      brow3 = ROW_479;
      bpos3 = POS_ROW_479;
    end else if (nx3 <= COL_LOW) begin
      rcol3 = WALL_279;
      rpos3 = POS_COL_279;
      brow3 = ROW_479;
      bpos3 = POS_ROW_479;
    end else if (nx3 <= COL_MID) begin
      rcol3 = WALL_399;
      rpos3 = POS_COL_399;
      brow3 = ROW_359;
      bpos3 = POS_ROW_359;
    end else if (nx3 <= COL_HIGH) begin
      rcol3 = WALL_519;
      rpos3 = POS_COL_519;
      brow3 = ROW_239;
      bpos3 = POS_ROW_239;
    end else begin
      rcol3 = WALL_639;
      rpos3 = POS_COL_639;
      brow3 = ROW_119;
      bpos3 = POS_ROW_119;
    end
    hb_st3 = ny3 >= brow3;
    hr3    = has_right3 && (nx3 >= rcol3);
  end

  logic signed [15:0] x_s4, y_s4, vx_s4, vy_s4, sx_s4, sy_s4, svx_s4, svy_s4;
  logic signed [15:0] ybnc_s4, xbnc_s4;
  logic signed [24:0] prf_s4, prs_s4;
  logic [7:0]         jf_s4, js_s4;
  logic               hit_y_s4, hit_x_s4, resp_s4, erase_s4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_s4     <= x_s3;
      y_s4     <= y_s3;
      vx_s4    <= vx_s3;
      vy_s4    <= vy_s3;
      sx_s4    <= sx_s3;
      sy_s4    <= sy_s3;
      svx_s4   <= svx_s3;
      svy_s4   <= svy_s3;
      prf_s4   <= fprod(vy_s3, cfg.rest_floor);
      prs_s4   <= fprod(vx_s3, cfg.rest_side);
      hit_y_s4 <= stair3 ? hb_st3 : (ny3 >= ROW_479);
      hit_x_s4 <= stair3 && hr3;
      ybnc_s4  <= stair3 ? bpos3 : POS_FLOOR;
      xbnc_s4  <= rpos3;
      resp_s4  <= !stair3 && (nx3 < left_px);
      jf_s4    <= jf_s3;
      js_s4    <= js_s3;
      erase_s4 <= erase_s3;
    end
  end

  // Stage 5: apply bounces, then the second respawn of the floor path.
  logic signed [15:0] vyb4, vxb4;

  always_comb begin
    vyb4 = 16'd0 - prf_s4[20:5] + {8'd0, jf_s4};
    vxb4 = 16'd0 - prs_s4[20:5] - {8'd0, js_s4};
  end

  logic signed [15:0] x_s5, y_s5, vx_s5, vy_s5;
  logic               hit_s5, erase_s5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (resp_s4) begin
        x_s5  <= sx_s4;
        y_s5  <= sy_s4;
        vx_s5 <= svx_s4;
        vy_s5 <= svy_s4;
      end else begin
        x_s5  <= hit_x_s4 ? xbnc_s4 : x_s4;
        y_s5  <= hit_y_s4 ? ybnc_s4 : y_s4;
        vx_s5 <= hit_x_s4 ? vxb4 : vx_s4;
        vy_s5 <= hit_y_s4 ? vyb4 : vy_s4;
      end
      hit_s5   <= hit_y_s4 || hit_x_s4;
      erase_s5 <= erase_s4;
    end
  end

  // Stage 6: advance the position and form the output transaction.
  logic signed [15:0] fx5, fy5;

  always_comb begin
    fx5 = x_s5 + vx_s5;
    fy5 = y_s5 + vy_s5;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      m_tdata <= {(OUT_DATA_W - OUT_FIELDS_W)'(0), !in_square(fx5, fy5), erase_s5, hit_s5,
                  vy_s5, vx_s5, fy5, fx5};
    end
  end

endmodule

### rtl/psbs_chk.sv
// Port-level checks for the particle staircase bounce step, bound to the top level.
module psbs_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [psbs_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import psbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Output transaction changed while stalled.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input not ready although the output stage is empty.");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0)
    else $error("Output fill bits are not zero.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid after reset.");

endmodule

bind particle_staircase_bounce_step_top psbs_chk u_psbs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
